### hw/rtl/solos_pkg.sv
// package for the sorted last-occurrence search core
// table geometry, state encoding and controller/datapath command and status structs
// no dependencies
`default_nettype none

package solos_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_USED_LENGTH = '0;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_PEEK,
        S_DONE
    } solos_state_t;

    typedef struct packed {
        logic wr_entry;
        logic start;
        logic rd_mid;
        logic rd_next;
        logic hi_to_mid;
        logic lo_past_mid;
        logic hit_mid;
        logic load_out;
    } solos_cmd_t;

    typedef struct packed {
        logic range_open;
        logic mem_gt;
        logic mem_lt;
        logic mid_last;
        logic mem_eq;
    } solos_status_t;

endpackage

`default_nettype wire

### hw/rtl/solos_if.sv
// request and response channel interfaces of the search core
// depends on solos_pkg
`default_nettype none

interface solos_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [solos_pkg::ADDR_W-1:0]       write_index;
    logic signed [solos_pkg::DATA_W-1:0] entry_value;
    logic signed [solos_pkg::DATA_W-1:0] search_key;

    modport source (output valid, req_type, write_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, req_type, write_index, entry_value, search_key,
                    output ready);
endinterface

interface solos_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [solos_pkg::ADDR_W-1:0] last_index;

    modport source (output valid, found, last_index, input ready);
    modport sink   (input valid, found, last_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/solos_ctrl.sv
// controller of the search core: sequences probes, peeks and result hand-off
// depends on solos_pkg
`default_nettype none

module solos_ctrl
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_req_type,
    output logic                          in_ready,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    input  wire solos_pkg::solos_status_t st,
    output solos_pkg::solos_cmd_t         cmd
);
    import solos_pkg::*;

    solos_state_t state_reg;
    solos_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_accept;
    logic         out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_req_type == REQ_SEARCH))
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = st.range_open ? S_CMP : S_DONE;
            end
            S_CMP:
            begin
                if (st.mem_gt || st.mem_lt)
                begin
                    state_next = S_PROBE;
                end
                else if (st.mid_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PEEK;
                end
            end
            S_PEEK:
            begin
                state_next = st.mem_eq ? S_PROBE : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.wr_entry = in_accept && (in_req_type == REQ_WRITE);
                cmd.start    = in_accept && (in_req_type == REQ_SEARCH);
            end
            S_PROBE:
            begin
                cmd.rd_mid = st.range_open;
            end
            S_CMP:
            begin
                cmd.hi_to_mid   = st.mem_gt;
                cmd.lo_past_mid = st.mem_lt;
                cmd.hit_mid     = !st.mem_gt && !st.mem_lt && st.mid_last;
                cmd.rd_next     = !st.mem_gt && !st.mem_lt && !st.mid_last;
            end
            S_PEEK:
            begin
                // next entry still equal: keep bisecting to the right
                cmd.lo_past_mid = st.mem_eq;
                cmd.hit_mid     = !st.mem_eq;
            end
            S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/solos_dp.sv
// datapath of the search core: table memory, bisection bounds, result register
// depends on solos_pkg
`default_nettype none

module solos_dp
(
    input  wire logic                               clk,
    input  wire solos_pkg::solos_cmd_t              cmd,
    input  wire logic [solos_pkg::ADDR_W-1:0]       write_index,
    input  wire logic signed [solos_pkg::DATA_W-1:0] entry_value,
    input  wire logic signed [solos_pkg::DATA_W-1:0] search_key,
    input  wire logic [solos_pkg::LEN_W-1:0]        used_length,
    output solos_pkg::solos_status_t                st,
    output logic                                    found,
    output logic [solos_pkg::ADDR_W-1:0]            last_index
);
    import solos_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic [LEN_W-1:0]         lo_reg;
    logic [LEN_W-1:0]         lo_next;
    logic [LEN_W-1:0]         hi_reg;     // exclusive upper bound
    logic [LEN_W-1:0]         hi_next;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [ADDR_W-1:0]        idx_reg;
    logic [ADDR_W-1:0]        idx_next;
    logic                     found_reg;
    logic [ADDR_W-1:0]        last_index_reg;
    logic [LEN_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid;
    logic [ADDR_W-1:0]        rd_addr;
    logic [LEN_W-1:0]         len_sat;

    assign len_sat = (used_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : used_length;

    // floor((lo + hi_incl) / 2) with hi_incl = hi - 1, only used while lo < hi
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (LEN_W+1)'(1);
    assign mid     = mid_sum[ADDR_W:1];
    assign rd_addr = cmd.rd_next ? (mid + ADDR_W'(1)) : mid;

    assign st.range_open = (lo_reg < hi_reg);
    assign st.mem_gt     = (rdata_reg > key_reg);
    assign st.mem_lt     = (rdata_reg < key_reg);
    assign st.mem_eq     = (rdata_reg == key_reg);
    assign st.mid_last   = ({1'b0, mid} == (len_reg - LEN_W'(1)));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            mem[write_index] <= entry_value;
        end
        if (cmd.rd_mid || cmd.rd_next)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        len_next = len_reg;
        key_next = key_reg;
        hit_next = hit_reg;
        idx_next = idx_reg;
        if (cmd.start)
        begin
            lo_next  = '0;
            hi_next  = len_sat;
            len_next = len_sat;
            key_next = search_key;
            hit_next = 1'b0;
            idx_next = '0;
        end
        if (cmd.hi_to_mid)
        begin
            hi_next = {1'b0, mid};
        end
        if (cmd.lo_past_mid)
        begin
            lo_next = {1'b0, mid} + LEN_W'(1);
        end
        if (cmd.hit_mid)
        begin
            hit_next = 1'b1;
            idx_next = mid;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        len_reg <= len_next;
        key_reg <= key_next;
        hit_reg <= hit_next;
        idx_reg <= idx_next;
        if (cmd.load_out)
        begin
            found_reg      <= hit_reg;
            last_index_reg <= idx_reg;
        end
    end

    assign found      = found_reg;
    assign last_index = last_index_reg;

endmodule

`default_nettype wire

### hw/rtl/sorted_last_occurrence_search_core.sv
// top level of the sorted last-occurrence search core: apb register, controller, datapath
// depends on solos_pkg, solos_if, solos_ctrl, solos_dp
//
// channel  dir  payload                                            handshake
// req      in   req_type, write_index, entry_value, search_key     valid/ready
// rsp      out  found, last_index                                  valid/ready
// apb      in   used_length at byte 0                              psel/penable
//
// a write beat is taken while idle; a search is accepted while idle, then runs its probes
// plus a peek at the next entry for each hit that is not the last used entry, a closing range
// check when the key is absent, and a load of the result register; up to
// log2(DEPTH)+1 probes, each a registered read of the single-port table memory
// followed by a compare. one search is in flight at a time.
// rsp holds its beat until taken; a finished search waits in place if rsp is full.
// reset clears control state and used_length; table contents are not cleared.
`default_nettype none

module sorted_last_occurrence_search_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    solos_req_if.sink                          req,
    solos_rsp_if.source                        rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [solos_pkg::PADDR_W-1:0] paddr,
    input  wire logic [solos_pkg::PDATA_W-1:0] pwdata,
    output logic [solos_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import solos_pkg::*;

    logic [LEN_W-1:0] used_length_reg;
    logic [LEN_W-1:0] used_length_next;
    logic             reg_sel;
    solos_cmd_t       cmd;
    solos_status_t    st;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_USED_LENGTH);

    always_comb
    begin
        used_length_next = used_length_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            used_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = {{(PDATA_W-LEN_W){1'b0}}, used_length_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_length_reg <= '0;
        end
        else
        begin
            used_length_reg <= used_length_next;
        end
    end

    solos_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .st          (st),
        .cmd         (cmd)
    );

    solos_dp u_dp
    (
        .clk         (clk),
        .cmd         (cmd),
        .write_index (req.write_index),
        .entry_value (req.entry_value),
        .search_key  (req.search_key),
        .used_length (used_length_reg),
        .st          (st),
        .found       (rsp.found),
        .last_index  (rsp.last_index)
    );

endmodule

`default_nettype wire

### test/testbench.sv
// self-checking testbench of the sorted last-occurrence search core
// loads sorted tables, sends key searches and checks every response beat against its own bisection
// depends on solos_pkg, solos_if and sorted_last_occurrence_search_core
`timescale 1ns / 100ps

module testbench;
    import solos_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 50;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic [PADDR_W-1:0] USED_LENGTH_ADDR = {REG_USED_LENGTH, 2'b00};
    localparam logic signed [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] last_index;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    solos_req_if req_ch();
    solos_rsp_if rsp_ch();

    // predictor state: table copy and used length as the core should see them
    logic signed [DATA_W-1:0] shadow_table [DEPTH];
    logic [LEN_W-1:0]         shadow_len = '0;
    answer_t                  pending_answers [$];

    // contents the stimulus means the table to hold, used to pick keys
    logic signed [DATA_W-1:0] plan [DEPTH];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int errors     = 0;
    int n_writes   = 0;
    int n_searches = 0;
    int n_hits     = 0;
    int n_results  = 0;
    int n_lengths  = 0;

    sorted_last_occurrence_search_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // bisection for the highest index holding the key among the used entries
    function automatic answer_t last_match(logic signed [DATA_W-1:0] key);
        int      n;
        int      lo;
        int      hi;
        int      mid;
        answer_t a;
        n  = (shadow_len > DEPTH) ? DEPTH : int'(shadow_len);
        lo = 0;
        hi = n - 1;
        a  = '0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_table[mid] > key)
                hi = mid - 1;
            else if (shadow_table[mid] < key)
                lo = mid + 1;
            else if (mid == n - 1 || shadow_table[mid + 1] != key) begin
                a.found      = 1'b1;
                a.last_index = ADDR_W'(mid);
                break;
            end
            else
                lo = mid + 1;
        end
        return a;
    endfunction

    always @(posedge clk) begin : monitor
        answer_t want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: response beat with no search waiting: found=%0b index=%0d",
                             $time, rsp_ch.found, rsp_ch.last_index);
            end
            else begin
                want = pending_answers.pop_front();
                if (rsp_ch.found !== want.found || rsp_ch.last_index !== want.last_index) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                 $time, want.found, want.last_index,
                                 rsp_ch.found, rsp_ch.last_index);
                end
            end
        end
        if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == REQ_WRITE) begin
                shadow_table[req_ch.write_index] = req_ch.entry_value;
                n_writes++;
            end
            else begin
                want = last_match(req_ch.search_key);
                pending_answers.push_back(want);
                n_searches++;
                if (want.found)
                    n_hits++;
            end
        end
        if (psel && penable && pwrite && pready) begin
            if (paddr == USED_LENGTH_ADDR)
                shadow_len = pwdata[LEN_W-1:0];
            n_lengths++;
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // response side: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_item(logic rtype, logic [ADDR_W-1:0] idx,
                             logic signed [DATA_W-1:0] value, logic signed [DATA_W-1:0] key);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rtype;
        req_ch.write_index <= idx;
        req_ch.entry_value <= value;
        req_ch.search_key  <= key;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
    endtask

    task automatic write_entry(logic [ADDR_W-1:0] idx, logic signed [DATA_W-1:0] value);
        plan[idx] = value;
        send_item(REQ_WRITE, idx, value, $urandom);
    endtask

    task automatic search_for(logic signed [DATA_W-1:0] key);
        send_item(REQ_SEARCH, ADDR_W'($urandom_range(0, DEPTH - 1)), $urandom, key);
    endtask

    // stop sending and let every search answer before touching the register
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(int len);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[LEN_W-1:0] = LEN_W'(len);
        if ($urandom_range(0, 3) != 0)
            data[PDATA_W-1:LEN_W] = '0;
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= USED_LENGTH_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!(psel && penable && pwrite && pready));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly keys present in the used range, then near misses, extremes and noise
    function automatic logic signed [DATA_W-1:0] pick_key();
        int                       n;
        int                       r;
        logic signed [DATA_W-1:0] k;
        n = (shadow_len > DEPTH) ? DEPTH : int'(shadow_len);
        r = $urandom_range(0, 99);
        k = $urandom;
        if (n > 0 && r < 60)
            k = plan[$urandom_range(0, n - 1)];
        else if (n > 0 && r < 80)
            k = plan[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (r < 85)
            k = KEY_MIN;
        else if (r < 90)
            k = KEY_MAX;
        return k;
    endfunction

    // narrow value ranges give long runs of equal entries and gaps between them
    task automatic make_sorted_plan(int n, bit wide);
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] v;
        int                       j;
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            v = wide ? $urandom : base + $urandom_range(0, n);
            j = i;
            while (j > 0 && plan[j - 1] > v) begin
                plan[j] = plan[j - 1];
                j--;
            end
            plan[j] = v;
        end
        if ($urandom_range(0, 4) == 0)
            plan[0] = KEY_MIN;
        if ($urandom_range(0, 4) == 0)
            plan[n - 1] = KEY_MAX;
    endtask

    task automatic load_plan(int n);
        bit down;
        down = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            int k;
            k = down ? n - 1 - i : i;
            write_entry(ADDR_W'(k), plan[k]);
        end
    endtask

    task automatic test_edge_cases();
        // used_length is zero out of reset: nothing can be found
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        search_for('0);
        plan[0] = KEY_MIN;
        plan[1] = KEY_MIN;
        plan[2] = -5;
        plan[3] = -1;
        plan[4] = 0;
        plan[5] = 0;
        plan[6] = 0;
        plan[7] = 7;
        plan[8] = KEY_MAX;
        plan[9] = KEY_MAX;
        load_plan(10);
        write_entry(ADDR_W'(DEPTH - 1), $urandom);
        set_length(10);
        search_for(KEY_MIN);
        search_for(-5);
        search_for(0);
        search_for(7);
        search_for(KEY_MAX);
        search_for(-3);
        search_for(8);
        // run of equal entries cut by the end of the used range
        set_length(9);
        search_for(KEY_MAX);
        set_length(1);
        search_for(KEY_MIN);
        set_length(0);
        search_for(0);
    endtask

    task automatic test_random_tables(int phases);
        int n;
        int r;
        int j;
        for (int p = 0; p < phases; p++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
            make_sorted_plan(n, $urandom_range(0, 3) == 0);
            load_plan(n);
            set_length(($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n);
            repeat ($urandom_range(8, 20)) begin
                r = $urandom_range(0, 99);
                j = $urandom_range(0, n - 1);
                if (r < 8)
                    write_entry(ADDR_W'($urandom_range(n, DEPTH - 1)), $urandom);
                else if (r < 12)
                    write_entry(ADDR_W'(j), plan[j]);
                else if (r < 14)
                    write_entry(ADDR_W'(j), $urandom);  // may break the ordering
                else
                    search_for(pick_key());
            end
        end
    endtask

    task automatic test_full_table();
        int lengths [5];
        lengths[0] = DEPTH;
        lengths[1] = 2 ** LEN_W - 1;  // saturates to the table size
        lengths[2] = DEPTH + 1;
        lengths[3] = DEPTH - 1;
        lengths[4] = $urandom_range(1, 2 ** LEN_W - 1);
        make_sorted_plan(DEPTH, 1'b0);
        load_plan(DEPTH);
        foreach (lengths[i]) begin
            set_length(lengths[i]);
            repeat (8) search_for(pick_key());
        end
    endtask

    task automatic test_output_stall();
        set_length($urandom_range(16, DEPTH));
        hold_requests++;
        repeat (16) search_for(pick_key());
        drain();
        repeat (16) search_for(pick_key());
    endtask

    task automatic test_unsorted();
        for (int i = 0; i < 24; i++)
            plan[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12);
        load_plan(24);
        set_length(24);
        repeat (20) search_for(pick_key());
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_WRITE;
        req_ch.write_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 29;
        rx_idle_pct = 66;
        test_edge_cases();
        test_random_tables(2);

        tx_idle_pct = 66;
        rx_idle_pct = 29;
        test_full_table();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_stall();
        test_unsorted();
        test_random_tables(1);

        drain();
        errors += pending_answers.size();
        $display("covered %0d table writes, %0d searches (%0d hits), %0d length settings",
                 n_writes, n_searches, n_hits, n_lengths);
        $display("%0d response beats checked, %0d failures", n_results, errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### sim.f
hw/rtl/solos_pkg.sv
hw/rtl/solos_if.sv
hw/rtl/solos_ctrl.sv
hw/rtl/solos_dp.sv
hw/rtl/sorted_last_occurrence_search_core.sv
test/testbench.sv
